/* rtl/cpct_pkg.sv */
// Shared widths, constants and the search stage record for the disc time-of-impact pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cpct_pkg;
   localparam int TimeBits = 16;
   localparam int TIME_W   = TimeBits + 1;
   localparam int POS_W    = 32;
   localparam int RAD_W    = 24;
   localparam int DIF_W    = POS_W + 1;
   localparam int MAG_W    = 2 * POS_W + 1;
   localparam int LO_W     = 32;
   localparam int HI_W     = MAG_W - LO_W;
   localparam int PP_W     = 2 * MAG_W;
   localparam int U_W      = MAG_W + TIME_W + 1;
   localparam int F_W      = MAG_W + 2 * TIME_W + 3;
   localparam logic [TIME_W-1:0] TimeOne = TIME_W'(1 << TimeBits);

   typedef struct packed {
      logic              vld;
      logic              ovl;
      logic              miss;
      logic [TIME_W-1:0] lim;
      logic [MAG_W-1:0]  a;
      logic [MAG_W-1:0]  m;
      logic [F_W-1:0]    f;
      logic [U_W-1:0]    u;
      logic [TIME_W-1:0] p;
   } srch_type;
endpackage
`default_nettype wire

/* rtl/cpct_search_stage.sv */
// One bit of the contact time search: incremental quadratic update by shifts and adds.
// Depends on cpct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpct_search_stage import cpct_pkg::*; #(
   parameter int BitPos = 0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire srch_type up_stage,
   output srch_type      dn_stage
);
   logic [F_W-1:0] f_cand;
   logic [U_W-1:0] u_cand;
   logic           keep;
   srch_type       stage_in;
   srch_type       stage_ff;

   // f(p+2^k) = f(p) + 2^(k+1)*A*p + A*2^2k - m*2^(17+k)
   always_comb begin
      u_cand = up_stage.u + (U_W'(up_stage.a) << BitPos);
      f_cand = up_stage.f + (F_W'(up_stage.u) << (BitPos + 1))
             + (F_W'(up_stage.a) << (2 * BitPos))
             - (F_W'(up_stage.m) << (TimeBits + 1 + BitPos));
      keep = (u_cand < (U_W'(up_stage.m) << TimeBits)) && !f_cand[F_W-1]
             && (f_cand != '0);
      stage_in = up_stage;
      if (keep) begin
         stage_in.f         = f_cand;
         stage_in.u         = u_cand;
         stage_in.p[BitPos] = 1'b1;
      end
      if (reset) begin
         stage_in.vld = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign dn_stage = stage_ff;
endmodule
`default_nettype wire

/* rtl/circle_pair_collision_time_top.sv */
// Moving disc pair time of impact, fully pipelined.
// Depends on cpct_pkg and cpct_search_stage.
//
//   channel | ports                    | transfer
//   req     | start, busy, req_*       | start high while busy low
//   rsp     | rsp_valid, rsp_hit, ...  | one cycle while rsp_valid high
//
// One item per cycle; the result passes six arithmetic stages, one stage per time bit of the
// shift-add search (17), then one output register.
// busy stays low: the pipeline never stalls; the receiver must take every result, which the block does not enforce.
// Synchronous reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module circle_pair_collision_time_top import cpct_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic signed [POS_W-1:0] req_pos_a_x,
   input  wire logic signed [POS_W-1:0] req_pos_a_y,
   input  wire logic signed [POS_W-1:0] req_vel_a_x,
   input  wire logic signed [POS_W-1:0] req_vel_a_y,
   input  wire logic [RAD_W-1:0]        req_radius_a,
   input  wire logic signed [POS_W-1:0] req_pos_b_x,
   input  wire logic signed [POS_W-1:0] req_pos_b_y,
   input  wire logic signed [POS_W-1:0] req_vel_b_x,
   input  wire logic signed [POS_W-1:0] req_vel_b_y,
   input  wire logic [RAD_W-1:0]        req_radius_b,
   input  wire logic [TIME_W-1:0]       req_time_now,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic [TIME_W-1:0]            rsp_time_to_hit
);
   // stage 1: differences
   logic                    s1_vld_ff;
   logic signed [DIF_W-1:0] s1_dpx_ff, s1_dpy_ff, s1_dvx_ff, s1_dvy_ff;
   logic [RAD_W:0]          s1_rad_ff;
   logic [TIME_W-1:0]       s1_tnow_ff;
   // stage 2: products
   logic                    s2_vld_ff;
   logic [2*POS_W-1:0]      s2_sx_ff, s2_sy_ff, s2_ax_ff, s2_ay_ff;
   logic signed [2*DIF_W-1:0] s2_px_ff, s2_py_ff;
   logic [2*RAD_W+1:0]      s2_r2_ff;
   logic                    s2_still_ff;
   logic [TIME_W-1:0]       s2_tnow_ff;
   // stage 3: coefficients
   logic                    s3_vld_ff, s3_ovl_ff, s3_miss_ff;
   logic [MAG_W-1:0]        s3_a_ff, s3_c_ff, s3_m_ff;
   logic [TIME_W-1:0]       s3_tnow_ff;
   // stage 4: partial products of m*m and A*C
   logic                    s4_vld_ff, s4_ovl_ff, s4_miss_ff;
   logic [MAG_W-1:0]        s4_a_ff, s4_c_ff, s4_m_ff;
   logic [TIME_W-1:0]       s4_tnow_ff;
   logic [2*HI_W-1:0]       s4_mhh_ff, s4_ahh_ff;
   logic [HI_W+LO_W-1:0]    s4_mhl_ff, s4_ahl_ff, s4_alh_ff;
   logic [2*LO_W-1:0]       s4_mll_ff, s4_pll_ff;
   // stage 5: full products
   logic                    s5_vld_ff, s5_ovl_ff, s5_miss_ff;
   logic [MAG_W-1:0]        s5_a_ff, s5_c_ff, s5_m_ff;
   logic [TIME_W-1:0]       s5_tnow_ff;
   logic [PP_W-1:0]         s5_mm_ff, s5_ac_ff;
   // stage 6 and search chain
   srch_type                s6_in, s6_ff;
   srch_type                chain [0:TimeBits+1];
   // output
   logic [TIME_W:0]         q_in;
   logic                    hit_in;
   logic                    rsp_valid_ff, rsp_hit_ff;
   logic [TIME_W-1:0]       rsp_time_ff;

   logic signed [2*DIF_W-1:0] sqx, sqy, svx, svy;
   logic [MAG_W-1:0]          sum_s;
   logic signed [2*DIF_W:0]   dot, ndot;

   assign busy = 1'b0;
   assign sqx  = (2*DIF_W)'(s1_dpx_ff) * (2*DIF_W)'(s1_dpx_ff);
   assign sqy  = (2*DIF_W)'(s1_dpy_ff) * (2*DIF_W)'(s1_dpy_ff);
   assign svx  = (2*DIF_W)'(s1_dvx_ff) * (2*DIF_W)'(s1_dvx_ff);
   assign svy  = (2*DIF_W)'(s1_dvy_ff) * (2*DIF_W)'(s1_dvy_ff);
   assign sum_s = MAG_W'(s2_sx_ff) + MAG_W'(s2_sy_ff);
   assign dot   = (2*DIF_W+1)'(s2_px_ff) + (2*DIF_W+1)'(s2_py_ff);
   assign ndot  = -dot;

   always_ff @(posedge clock) begin
      s1_dpx_ff  <= DIF_W'(req_pos_a_x) - DIF_W'(req_pos_b_x);
      s1_dpy_ff  <= DIF_W'(req_pos_a_y) - DIF_W'(req_pos_b_y);
      s1_dvx_ff  <= DIF_W'(req_vel_a_x) - DIF_W'(req_vel_b_x);
      s1_dvy_ff  <= DIF_W'(req_vel_a_y) - DIF_W'(req_vel_b_y);
      s1_rad_ff  <= (RAD_W+1)'(req_radius_a) + (RAD_W+1)'(req_radius_b);
      s1_tnow_ff <= req_time_now;

      s2_sx_ff    <= sqx[2*POS_W-1:0];
      s2_sy_ff    <= sqy[2*POS_W-1:0];
      s2_ax_ff    <= svx[2*POS_W-1:0];
      s2_ay_ff    <= svy[2*POS_W-1:0];
      s2_px_ff    <= (2*DIF_W)'(s1_dpx_ff) * (2*DIF_W)'(s1_dvx_ff);
      s2_py_ff    <= (2*DIF_W)'(s1_dpy_ff) * (2*DIF_W)'(s1_dvy_ff);
      s2_r2_ff    <= (2*RAD_W+2)'(s1_rad_ff) * (2*RAD_W+2)'(s1_rad_ff);
      s2_still_ff <= (s1_dvx_ff == '0) && (s1_dvy_ff == '0);
      s2_tnow_ff  <= s1_tnow_ff;

      s3_ovl_ff  <= sum_s <= MAG_W'(s2_r2_ff);
      s3_c_ff    <= sum_s - MAG_W'(s2_r2_ff);
      s3_a_ff    <= MAG_W'(s2_ax_ff) + MAG_W'(s2_ay_ff);
      s3_m_ff    <= ndot[MAG_W-1:0];
      s3_miss_ff <= s2_still_ff || !dot[2*DIF_W];
      s3_tnow_ff <= s2_tnow_ff;

      s4_mhh_ff  <= (2*HI_W)'(s3_m_ff[MAG_W-1:LO_W]) * (2*HI_W)'(s3_m_ff[MAG_W-1:LO_W]);
      s4_mhl_ff  <= (HI_W+LO_W)'(s3_m_ff[MAG_W-1:LO_W]) * (HI_W+LO_W)'(s3_m_ff[LO_W-1:0]);
      s4_mll_ff  <= (2*LO_W)'(s3_m_ff[LO_W-1:0]) * (2*LO_W)'(s3_m_ff[LO_W-1:0]);
      s4_ahh_ff  <= (2*HI_W)'(s3_a_ff[MAG_W-1:LO_W]) * (2*HI_W)'(s3_c_ff[MAG_W-1:LO_W]);
      s4_ahl_ff  <= (HI_W+LO_W)'(s3_a_ff[MAG_W-1:LO_W]) * (HI_W+LO_W)'(s3_c_ff[LO_W-1:0]);
      s4_alh_ff  <= (HI_W+LO_W)'(s3_a_ff[LO_W-1:0]) * (HI_W+LO_W)'(s3_c_ff[MAG_W-1:LO_W]);
      s4_pll_ff  <= (2*LO_W)'(s3_a_ff[LO_W-1:0]) * (2*LO_W)'(s3_c_ff[LO_W-1:0]);
      s4_a_ff    <= s3_a_ff;
      s4_c_ff    <= s3_c_ff;
      s4_m_ff    <= s3_m_ff;
      s4_ovl_ff  <= s3_ovl_ff;
      s4_miss_ff <= s3_miss_ff;
      s4_tnow_ff <= s3_tnow_ff;

      s5_mm_ff   <= (PP_W'(s4_mhh_ff) << (2*LO_W)) + (PP_W'(s4_mhl_ff) << (LO_W+1))
                    + PP_W'(s4_mll_ff);
      s5_ac_ff   <= (PP_W'(s4_ahh_ff) << (2*LO_W))
                    + ((PP_W'(s4_ahl_ff) + PP_W'(s4_alh_ff)) << LO_W) + PP_W'(s4_pll_ff);
      s5_a_ff    <= s4_a_ff;
      s5_c_ff    <= s4_c_ff;
      s5_m_ff    <= s4_m_ff;
      s5_ovl_ff  <= s4_ovl_ff;
      s5_miss_ff <= s4_miss_ff;
      s5_tnow_ff <= s4_tnow_ff;

      s6_ff <= s6_in;

      rsp_hit_ff  <= hit_in;
      rsp_time_ff <= (hit_in && !chain[TimeBits+1].ovl) ? q_in[TIME_W-1:0] : '0;

      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         s5_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= start;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         s5_vld_ff    <= s4_vld_ff;
         rsp_valid_ff <= chain[TimeBits+1].vld;
      end
   end

   always_comb begin
      s6_in.vld  = s5_vld_ff && !reset;
      s6_in.ovl  = s5_ovl_ff;
      s6_in.miss = s5_miss_ff || (s5_mm_ff < s5_ac_ff) || (s5_tnow_ff > TimeOne);
      s6_in.lim  = TimeOne - s5_tnow_ff;
      s6_in.a    = s5_a_ff;
      s6_in.m    = s5_m_ff;
      s6_in.f    = F_W'(s5_c_ff) << (2*TimeBits);
      s6_in.u    = '0;
      s6_in.p    = '0;
   end

   assign chain[0] = s6_ff;

   for (genvar gi = 0; gi <= TimeBits; gi++) begin : g_search
      cpct_search_stage #(
         .BitPos(TimeBits - gi)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .up_stage(chain[gi]),
         .dn_stage(chain[gi+1])
      );
   end

   // last time not yet in contact is p, so the rounded-up contact time is p + 1
   assign q_in   = (TIME_W+1)'(chain[TimeBits+1].p) + (TIME_W+1)'(1);
   assign hit_in = chain[TimeBits+1].ovl
                   || (!chain[TimeBits+1].miss && (q_in <= (TIME_W+1)'(chain[TimeBits+1].lim)));

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_time_to_hit = rsp_time_ff;
endmodule
`default_nettype wire
